// File: design/b64d_pkg.sv
// Shared types and constants for the base64 stream decoder.
package b64d_pkg;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_DIGIT_LO = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'd57;
   localparam logic [7:0] CHAR_UPPER_LO = 8'd65;
   localparam logic [7:0] CHAR_UPPER_HI = 8'd90;
   localparam logic [7:0] CHAR_LOWER_LO = 8'd97;
   localparam logic [7:0] CHAR_LOWER_HI = 8'd122;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_SLASH    = 8'h2F;
   localparam logic [7:0] CHAR_PAD      = 8'h3D;

   localparam logic [5:0] SEXTET_PAD    = 6'd61;
   localparam logic [5:0] SEXTET_PLUS   = 6'd62;
   localparam logic [5:0] SEXTET_SLASH  = 6'd63;

   typedef struct packed {
      logic [7:0] char_in;
      logic       stream_last;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [1:0] byte_count;
      logic       stream_end;
      logic       partial_dropped;
   } rsp_type;

   // classified character as queued between front and back
   typedef struct packed {
      logic [5:0] sextet;
      logic       char_ok;
      logic       is_pad;
      logic       is_last;
   } qentry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// File: design/b64d_front.sv
// Front end: classifies each input character and pushes kept items to the queue.
module b64d_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  b64d_pkg::req_type    req_data,
   input  b64d_pkg::qstat_type  q_stat,
   output logic                 push_en,
   output b64d_pkg::qentry_type push_data
);
   import b64d_pkg::*;

   logic [7:0] c;
   logic       ok;
   logic [5:0] sx;

   assign c = req_data.char_in;

   always_comb begin
      ok = 1'b1;
      sx = 6'd0;
      priority if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
         sx = 6'(c - CHAR_DIGIT_LO + 8'd52);
      end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
         sx = 6'(c - CHAR_UPPER_LO);
      end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
         sx = 6'(c - CHAR_LOWER_LO + 8'd26);
      end else if (c == CHAR_PLUS) begin
         sx = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         sx = SEXTET_SLASH;
      end else if (c == CHAR_PAD) begin
         sx = SEXTET_PAD;
      end else begin
         ok = 1'b0;
      end
   end

   assign req_ready = !q_stat.full;

   // skipped characters vanish here unless they close the stream
   assign push_en = req_valid && !q_stat.full && (ok || req_data.stream_last);

   assign push_data.sextet  = sx;
   assign push_data.char_ok = ok;
   assign push_data.is_pad  = (c == CHAR_PAD);
   assign push_data.is_last = req_data.stream_last;

endmodule

// File: design/b64d_queue.sv
// Short flop queue between the classifier and the group assembler.
module b64d_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_en,
   input  b64d_pkg::qentry_type push_data,
   input  logic                 pop_en,
   output b64d_pkg::qentry_type head_data,
   output b64d_pkg::qstat_type  q_stat
);
   import b64d_pkg::*;

   qentry_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       do_push, do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push      = push_en && !q_stat.full;
   assign do_pop       = pop_en && !q_stat.empty;
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_ADDR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_ADDR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/b64d_back.sv
// Back end: assembles sextet groups into bytes and holds the result register.
module b64d_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64d_pkg::qentry_type head_data,
   input  b64d_pkg::qstat_type  q_stat,
   output logic                 pop_en,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output b64d_pkg::rsp_type    rsp_data
);
   import b64d_pkg::*;

   logic [17:0] held_ff, held_in;
   logic [1:0]  pos_ff, pos_in;
   logic        third_pad_ff, third_pad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        group_done;
   logic        makes_result;
   logic        slot_free;
   rsp_type     res;

   assign group_done   = head_data.char_ok && (pos_ff == 2'd3);
   assign makes_result = group_done || head_data.is_last;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign pop_en       = !q_stat.empty && (!makes_result || slot_free);

   always_comb begin
      held_in      = held_ff;
      pos_in       = pos_ff;
      third_pad_in = third_pad_ff;
      res          = '0;
      if (head_data.char_ok) begin
         if (!group_done) begin
            if (pos_ff == 2'd2) begin
               third_pad_in = head_data.is_pad;
            end
            held_in = {held_ff[11:0], head_data.sextet};
            pos_in  = 2'(pos_ff + 1'b1);
         end else begin
            res.byte_first = held_ff[17:10];
            if (head_data.is_pad) begin
               if (third_pad_ff) begin
                  res.byte_count = 2'd1;
               end else begin
                  res.byte_second = held_ff[9:2];
                  res.byte_count  = 2'd2;
               end
            end else begin
               res.byte_second = held_ff[9:2];
               res.byte_third  = {held_ff[1:0], head_data.sextet};
               res.byte_count  = 2'd3;
            end
            held_in      = '0;
            pos_in       = '0;
            third_pad_in = 1'b0;
         end
      end
      res.stream_end      = head_data.is_last;
      res.partial_dropped = head_data.is_last && !group_done && (pos_in != 2'd0);
      if (head_data.is_last) begin
         held_in      = '0;
         pos_in       = '0;
         third_pad_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop_en && makes_result) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         pos_ff       <= '0;
         third_pad_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_en) begin
            held_ff      <= held_in;
            pos_ff       <= pos_in;
            third_pad_ff <= third_pad_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_drop_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.partial_dropped |-> rsp_ff.stream_end &&
      (rsp_ff.byte_count == 2'd0))
      else $error("dropped group flagged on a result that does not close the stream");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop_en && head_data.is_last |=> (pos_ff == 2'd0) && !third_pad_ff)
      else $error("group state not cleared after stream end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result lost or changed");

   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      pop_en && makes_result |-> slot_free)
      else $error("result popped with no room in the output register");

endmodule

// File: design/base64_stream_decoder_top.sv
// An accepted character is first written into the queue register; the group assembler
// then loads any result that the character completes into the output register.
// Throughput: one character per cycle; a 4-entry queue decouples the classifier
// from the assembler, and req_ready drops only when that queue is full.
// Reset (synchronous, active high) empties the queue and clears the group state and rsp_valid.
// Top level of the base64 stream decoder.
module base64_stream_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64d_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   qstat_type  q_stat;
   qentry_type push_data;
   qentry_type head_data;
   logic       push_en;
   logic       pop_en;

   b64d_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push_en   (push_en),
      .push_data (push_data)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .pop_en    (pop_en),
      .head_data (head_data),
      .q_stat    (q_stat)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_stat    (q_stat),
      .pop_en    (pop_en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
